/* rtl/rmsef_pkg.sv */
`timescale 1ns / 1ps
// rmsef_pkg: shared types, register indexes and constants of the rms envelope follower
package rmsef_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int GAIN_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int RAD_W      = 32;
    localparam int SQRT_STEPS = RAD_W / 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_WEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_WEIGHT  = 2'd3;

    // register reset values
    localparam logic [LEVEL_W-1:0] NOISE_FLOOR_RST   = 16'd655;
    localparam logic [GAIN_W-1:0]  LEVEL_GAIN_RST    = 12'd1536;
    localparam logic [LEVEL_W-1:0] ATTACK_WEIGHT_RST = 16'd39322;
    localparam logic [LEVEL_W-1:0] DECAY_WEIGHT_RST  = 16'd9830;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_chunk;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] energy;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_SQ_INIT,
        ST_SQRT,
        ST_SCALE,
        ST_MUL,
        ST_LEVEL,
        ST_ENV_MUL,
        ST_ENV_OUT
    } state_t;

    typedef struct packed {
        logic take;
        logic acc;
        logic div_step;
        logic sq_init;
        logic sq_step;
        logic scale;
        logic mul;
        logic level;
        logic env_mul;
        logic env_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic chunk_end;
        logic chunk_ok;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/rmsef_ctrl.sv */
`timescale 1ns / 1ps
// rmsef_ctrl: sequencer for accumulate, divide, square root and envelope update
module rmsef_ctrl #(
    parameter int SUM_W = 39
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rmsef_pkg::dp_status_t status,
    output rmsef_pkg::ctrl_cmd_t  cmd,
    output logic                  busy
);
    import rmsef_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.chunk_end && status.chunk_ok)
                begin
                    state_next = ST_DIV;
                    step_next  = STEP_W'(SUM_W - 1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                    state_next = ST_SQ_INIT;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_SQ_INIT:
            begin
                cmd.sq_init = 1'b1;
                state_next  = ST_SQRT;
                step_next   = STEP_W'(SQRT_STEPS - 1);
            end
            ST_SQRT:
            begin
                cmd.sq_step = 1'b1;
                if (step_reg == '0)
                    state_next = ST_SCALE;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = ST_ENV_MUL;
            end
            ST_ENV_MUL:
            begin
                cmd.env_mul = 1'b1;
                state_next  = ST_ENV_OUT;
            end
            ST_ENV_OUT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.env_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/rmsef_datapath.sv */
`timescale 1ns / 1ps
// rmsef_datapath: accumulator, serial divider, serial square root, level and envelope math
module rmsef_datapath #(
    parameter int CHUNK_SAMPLES = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rmsef_pkg::ctrl_cmd_t                   cmd,
    output rmsef_pkg::dp_status_t                  status,
    input  rmsef_pkg::in_item_t                    in_data,
    input  logic                                   cfg_wr_en,
    input  logic [rmsef_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rmsef_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output rmsef_pkg::out_item_t                   out_data
);
    import rmsef_pkg::*;

    localparam int CNT_W = $clog2(CHUNK_SAMPLES + 1);
    localparam int SQ_W  = 2 * SAMPLE_W - 1;
    localparam int SUM_W = SQ_W + $clog2(CHUNK_SAMPLES);

    // configuration
    logic [LEVEL_W-1:0] noise_floor_reg;
    logic [GAIN_W-1:0]  level_gain_reg;
    logic [LEVEL_W-1:0] attack_weight_reg;
    logic [LEVEL_W-1:0] decay_weight_reg;

    // accumulation
    logic [SAMPLE_W:0]     mag;
    logic [2*SAMPLE_W+1:0] sq_full;
    logic [SQ_W-1:0]       sq_reg;
    logic                  last_reg;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // divider
    logic [SUM_W-1:0] dvd_reg;
    logic [CNT_W-1:0] dvs_reg;
    logic [CNT_W-1:0] drem_reg;
    logic [CNT_W:0]   dshift;
    logic [CNT_W:0]   dsub;
    logic             dge;

    // square root
    logic [RAD_W-1:0]        rad_reg;
    logic [LEVEL_W+1:0]      sqrem_reg;
    logic [LEVEL_W-1:0]      root_reg;
    logic [LEVEL_W+3:0]      s_sh;
    logic [LEVEL_W+3:0]      s_trial;
    logic [LEVEL_W+3:0]      s_sub;
    logic                    sge;

    // level and envelope
    logic [LEVEL_W:0]          dbl;
    logic [LEVEL_W-1:0]        norm;
    logic [LEVEL_W-1:0]        diff_reg;
    logic [LEVEL_W+GAIN_W-1:0] scaled_reg;
    logic [LEVEL_W-1:0]        level_val;
    logic [LEVEL_W-1:0]        level_reg;
    logic [LEVEL_W-1:0]        wt_reg;
    logic [LEVEL_W:0]          inv_wt;
    logic [2*LEVEL_W:0]        p_env_reg;
    logic [2*LEVEL_W-1:0]      p_lvl_reg;
    logic [2*LEVEL_W+1:0]      env_sum;
    logic [LEVEL_W-1:0]        env_new;
    logic [LEVEL_W-1:0]        env_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    // magnitude and square of the incoming sample
    assign mag     = 17'd0 - {in_data.sample[SAMPLE_W-1], in_data.sample};
    assign sq_full = in_data.sample[SAMPLE_W-1]
                   ? mag * mag
                   : {{(SAMPLE_W+1){1'b0}}, 1'b0, in_data.sample} *
                     {{(SAMPLE_W+1){1'b0}}, 1'b0, in_data.sample};

    assign sum_next = sum_reg + SUM_W'(sq_reg);
    assign cnt_next = cnt_reg + 1'b1;

    assign status.chunk_end = last_reg || (cnt_next == CNT_W'(CHUNK_SAMPLES));
    assign status.chunk_ok  = (cnt_next >= CNT_W'(2));
    assign status.out_free  = !out_valid_reg || !out_stall;

    // restoring divide, one quotient bit a step
    assign dshift = {drem_reg, dvd_reg[SUM_W-1]};
    assign dge    = (dshift >= {1'b0, dvs_reg});
    assign dsub   = dshift - {1'b0, dvs_reg};

    // digit-by-digit root, two radicand bits a step
    assign s_sh    = {sqrem_reg, rad_reg[RAD_W-1 -: 2]};
    assign s_trial = {2'b00, root_reg, 2'b01};
    assign sge     = (s_sh >= s_trial);
    assign s_sub   = s_sh - s_trial;

    assign dbl       = {root_reg, 1'b0};
    assign norm      = dbl[LEVEL_W] ? {LEVEL_W{1'b1}} : dbl[LEVEL_W-1:0];
    assign level_val = (scaled_reg[LEVEL_W+GAIN_W-1:LEVEL_W+8] != '0)
                     ? {LEVEL_W{1'b1}} : scaled_reg[LEVEL_W+7:8];
    assign inv_wt    = 17'h10000 - {1'b0, wt_reg};
    assign env_sum   = {1'b0, p_env_reg} + {2'b00, p_lvl_reg} + 34'd32768;
    assign env_new   = env_sum[2*LEVEL_W-1:LEVEL_W];

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_floor_reg   <= NOISE_FLOOR_RST;
            level_gain_reg    <= LEVEL_GAIN_RST;
            attack_weight_reg <= ATTACK_WEIGHT_RST;
            decay_weight_reg  <= DECAY_WEIGHT_RST;
            sum_reg           <= '0;
            cnt_reg           <= '0;
            env_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_NOISE_FLOOR:   noise_floor_reg   <= cfg_data;
                    REG_LEVEL_GAIN:    level_gain_reg    <= cfg_data[GAIN_W-1:0];
                    REG_ATTACK_WEIGHT: attack_weight_reg <= cfg_data;
                    REG_DECAY_WEIGHT:  decay_weight_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.acc)
            begin
                if (status.chunk_end)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                end
            end
            if (cmd.env_out)
            begin
                env_reg       <= env_new;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sq_reg   <= sq_full[SQ_W-1:0];
            last_reg <= in_data.last_in_chunk;
        end
        if (cmd.acc)
        begin
            dvd_reg  <= sum_next;
            dvs_reg  <= cnt_next;
            drem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            drem_reg <= dge ? dsub[CNT_W-1:0] : dshift[CNT_W-1:0];
            dvd_reg  <= {dvd_reg[SUM_W-2:0], dge};
        end
        if (cmd.sq_init)
        begin
            rad_reg   <= dvd_reg[RAD_W-1:0];
            sqrem_reg <= '0;
            root_reg  <= '0;
        end
        if (cmd.sq_step)
        begin
            sqrem_reg <= sge ? s_sub[LEVEL_W+1:0] : s_sh[LEVEL_W+1:0];
            root_reg  <= {root_reg[LEVEL_W-2:0], sge};
            rad_reg   <= {rad_reg[RAD_W-3:0], 2'b00};
        end
        if (cmd.scale)
            diff_reg <= (norm > noise_floor_reg) ? norm - noise_floor_reg : '0;
        if (cmd.mul)
            scaled_reg <= diff_reg * level_gain_reg;
        if (cmd.level)
        begin
            level_reg <= level_val;
            wt_reg    <= (level_val > env_reg) ? attack_weight_reg : decay_weight_reg;
        end
        if (cmd.env_mul)
        begin
            p_env_reg <= env_reg * inv_wt;
            p_lvl_reg <= level_reg * wt_reg;
        end
        if (cmd.env_out)
        begin
            out_data_reg.level  <= level_reg;
            out_data_reg.energy <= env_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/rms_envelope_follower_unit.sv */
`timescale 1ns / 1ps
// rms_envelope_follower_unit: top level of the chunked rms level meter with envelope
// an item that does not end a chunk is squared on accept, then accumulated
// a chunk end with two samples or more then runs the serial divide, the serial square root
// and the level/envelope steps, the last of which waits until the output register is free
// one item is worked on at a time; the output register lets a finished result wait
// reset (rst_n, async, active low) clears sums, count, envelope and loads register defaults
module rms_envelope_follower_unit #(
    parameter int CHUNK_SAMPLES = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rmsef_pkg::in_item_t               in_data,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output rmsef_pkg::out_item_t              out_data,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [rmsef_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmsef_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rmsef_pkg::*;

    // sum of squares width: one square plus growth over a full chunk
    localparam int SUM_W = 2 * SAMPLE_W - 1 + $clog2(CHUNK_SAMPLES);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       busy;

    // the sequencer takes an item only when it is idle
    assign in_stall = busy;

    rmsef_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    // accumulator, divider, root and envelope math plus the output register
    rmsef_datapath #(
        .CHUNK_SAMPLES (CHUNK_SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // an accepted item always occupies the block for at least the next cycle
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while the previous one was still in work");

    // with no input the idle block stays idle
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && !in_valid |=> !in_stall)
        else $error("block left idle without an item");

    // a new result can only come out of a chunk that was in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the block was idle");

endmodule
